// ===== rtl/bgrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgrf_pkg
// Shared types, field widths, command and status codes and small helpers
// for the bit-granular ring FIFO.
// ----------------------------------------------------------------------------
package bgrf_pkg;

   localparam int STORE_DEPTH_DEF = 1024;
   localparam int SIZE_RESET      = 1024;

   localparam int SIZE_W   = 11;
   localparam int CMD_W    = 2;
   localparam int DATA_W   = 8;
   localparam int CNT_W    = 4;
   localparam int OFFSET_W = 13;
   localparam int HELD_W   = 14;
   localparam int BYTES_W  = 11;
   localparam int STATUS_W = 2;

   localparam logic [CNT_W-1:0] MAX_BITS = 4'd8;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SHORT    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_PEEK_ERR = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [DATA_W-1:0]   data_in;
      logic [CNT_W-1:0]    bit_count;
      logic [OFFSET_W-1:0] bit_offset;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [CNT_W-1:0]    bits_read;
      logic [STATUS_W-1:0] status;
      logic [HELD_W-1:0]   bits_held;
      logic [BYTES_W-1:0]  bytes_held;
   } rsp_type;

   // Outcome of merging new bits into a two-byte window
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       spill;
      logic [7:0] peek_bits;
   } merge_type;

   // Top n bits set, n in 0..8
   function automatic logic [7:0] top_mask(input logic [CNT_W-1:0] n);
      logic [15:0] t;
      t = 16'hff00 >> n;
      return t[7:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bgrf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgrf_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module bgrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bgrf_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

// ===== rtl/bgrf_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgrf_merge
// Bit insert and extract on a two-byte window starting at a bit position.
// ----------------------------------------------------------------------------
module bgrf_merge (
   input  wire logic [15:0]                  win,
   input  wire logic [2:0]                   bit_pos,
   input  wire logic [bgrf_pkg::CNT_W-1:0]   cnt,
   input  wire logic [bgrf_pkg::DATA_W-1:0]  data,
   input  wire logic                         same_addr,
   output      bgrf_pkg::merge_type          result
);
   import bgrf_pkg::*;

   logic [15:0] mask16;
   logic [15:0] data16;
   logic [15:0] wnew;
   logic [15:0] shifted;

   always_comb begin
      mask16  = {top_mask(cnt), 8'h00} >> bit_pos;
      data16  = {data, 8'h00} >> bit_pos;
      wnew    = (win & ~mask16) | (data16 & mask16);
      shifted = win << bit_pos;
      // a one-byte ring wraps back onto the same byte: fold the low half in
      if (same_addr) begin
         result.byte0 = (wnew[15:8] & ~mask16[7:0]) | (wnew[7:0] & mask16[7:0]);
      end else begin
         result.byte0 = wnew[15:8];
      end
      result.byte1     = wnew[7:0];
      result.spill     = (mask16[7:0] != 8'h00) && !same_addr;
      result.peek_bits = shifted[15:8];
   end

endmodule
`default_nettype wire

// ===== rtl/bit_granular_ring_fifo_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bit_granular_ring_fifo_unit
// Bit-granular circular FIFO kept in a byte RAM, with write, read, peek and
// clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_item and raise start; the command transfers
//   at a rising edge where start is high and busy is low. Result channel:
//   rsp_item is valid for exactly one cycle while rsp_strobe is high; the
//   receiver cannot hold it off. csr_wr_en/csr_wr_data set the ring size in
//   bytes (zero acts as one, values above STORE_DEPTH act as STORE_DEPTH)
//   and empty the queue; write it only while no command is in flight.
// Command sequence:
//   Read, clear and writes that stay inside one byte: one state reads the
//   two window bytes from the RAM, the next modifies and writes back. A
//   write that spills into the next byte adds a state that writes the
//   second byte (the RAM has one write port). A peek adds a state before
//   these that wraps the peek position. Busy stays high until the strobe,
//   which comes the cycle after the last state; the next command may transfer in that same cycle.
// Reset:
//   Pointers and count go to zero and the ring size to 1024 bytes. The RAM
//   is not swept: a high-water mark of touched bytes makes every byte beyond
//   it read as zero, so commands are taken right after reset.
// ----------------------------------------------------------------------------
module bit_granular_ring_fifo_unit #(
   parameter int STORE_DEPTH = bgrf_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire bgrf_pkg::req_type             req_item,
   output      logic                          rsp_strobe,
   output      bgrf_pkg::rsp_type             rsp_item,
   input  wire logic                          csr_wr_en,
   input  wire logic [bgrf_pkg::SIZE_W-1:0]   csr_wr_data
);
   import bgrf_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);      // byte address
   localparam int RW = $clog2(STORE_DEPTH + 1);  // byte count up to the depth
   localparam int PW = RW + 3;                   // bit positions and bit counts
   localparam int SW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;  // peek sum
   localparam int CW = (SIZE_W > RW) ? SIZE_W : RW;            // size compare
   localparam int RING_RESET = (SIZE_RESET > STORE_DEPTH) ? STORE_DEPTH : SIZE_RESET;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADDR = 2'd1;
   localparam logic [1:0] ST_MOD  = 2'd2;
   localparam logic [1:0] ST_WR2  = 2'd3;

   // control state
   logic [1:0]    state_ff, state_in;
   logic [RW-1:0] ring_ff, ring_in;
   logic [RW-1:0] hw_ff, hw_in;          // bytes [0, hw) have been written
   logic [AW-1:0] wr_byte_ff, wr_byte_in;
   logic [2:0]    wr_bit_ff, wr_bit_in;
   logic [AW-1:0] rd_byte_ff, rd_byte_in;
   logic [2:0]    rd_bit_ff, rd_bit_in;
   logic [PW-1:0] held_ff, held_in;
   logic          strobe_ff, strobe_in;

   // per-command payload
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              bad_ff, bad_in;
   logic [SW-1:0]     psum_ff, psum_in;
   logic [2:0]        bit_ff, bit_in;
   logic [AW-1:0]     addr0_ff, addr0_in;
   logic [AW-1:0]     addr1_ff, addr1_in;
   logic [7:0]        wr2_data_ff, wr2_data_in;
   rsp_type           rsp_ff, rsp_in;

   logic          accept;
   logic [CNT_W-1:0] cnt_c;
   logic [SW-1:0] cap_s;
   logic [SW-1:0] pwrap;
   logic [AW-1:0] base_byte;
   logic [2:0]    base_bit;
   logic [RW-1:0] base_inc;
   logic [AW-1:0] base_next;

   logic [7:0]    rd_data_a, rd_data_b;
   logic [7:0]    z0, z1;
   merge_type     mrg;

   logic [PW:0]   held_plus;
   logic          overflow;
   logic [CNT_W-1:0] k;
   logic [CNT_W-1:0] step;
   logic [CNT_W-1:0] bsum;
   logic [PW:0]   held_up;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [RW-1:0] waddr_inc;

   logic [CW-1:0] size_ext;

   assign busy       = reset | (state_ff != ST_IDLE);
   assign accept     = start & ~busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // ------------------------------------------------------------------
   // Read address: the two bytes holding the window for this command.
   // A peek first registers read point plus offset, then wraps it here.
   // ------------------------------------------------------------------
   always_comb begin
      cnt_c   = (req_item.bit_count > MAX_BITS) ? MAX_BITS : req_item.bit_count;
      cap_s   = SW'({ring_ff, 3'b000});
      psum_in = SW'({rd_byte_ff, rd_bit_ff}) + SW'(req_item.bit_offset);
      bad_in  = SW'(req_item.bit_offset) >= cap_s;
      pwrap   = (psum_ff >= cap_s) ? (psum_ff - cap_s) : psum_ff;

      if (state_ff == ST_ADDR) begin
         base_byte = pwrap[AW+2:3];
         base_bit  = pwrap[2:0];
      end else if (req_item.command == CMD_WRITE) begin
         base_byte = wr_byte_ff;
         base_bit  = wr_bit_ff;
      end else begin
         base_byte = rd_byte_ff;
         base_bit  = rd_bit_ff;
      end
      // next byte around the ring
      base_inc  = RW'(base_byte) + RW'(1);
      base_next = (base_inc == ring_ff) ? '0 : base_inc[AW-1:0];
   end

   bgrf_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (base_byte),
      .rd_data_a (rd_data_a),
      .rd_addr_b (base_next),
      .rd_data_b (rd_data_b)
   );

   // bytes never written read as zero, as after a cleared store
   assign z0 = (RW'(addr0_ff) < hw_ff) ? rd_data_a : 8'h00;
   assign z1 = (RW'(addr1_ff) < hw_ff) ? rd_data_b : 8'h00;

   bgrf_merge u_merge (
      .win       ({z0, z1}),
      .bit_pos   (bit_ff),
      .cnt       (cnt_ff),
      .data      (data_ff),
      .same_addr (addr0_ff == addr1_ff),
      .result    (mrg)
   );

   // ------------------------------------------------------------------
   // Modify and write back, pointer and count update, result build
   // ------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      ring_in     = ring_ff;
      wr_byte_in  = wr_byte_ff;
      wr_bit_in   = wr_bit_ff;
      rd_byte_in  = rd_byte_ff;
      rd_bit_in   = rd_bit_ff;
      held_in     = held_ff;
      strobe_in   = 1'b0;
      cmd_in      = cmd_ff;
      data_in     = data_ff;
      cnt_in      = cnt_ff;
      bit_in      = bit_ff;
      addr0_in    = addr0_ff;
      addr1_in    = addr1_ff;
      wr2_data_in = wr2_data_ff;
      rsp_in      = rsp_ff;
      ram_we      = 1'b0;
      ram_waddr   = addr0_ff;
      ram_wdata   = mrg.byte0;

      held_plus = {1'b0, held_ff} + (PW+1)'(cnt_ff);
      overflow  = held_plus > {1'b0, PW'({ring_ff, 3'b000})};
      k         = (PW'(cnt_ff) < held_ff) ? cnt_ff : held_ff[CNT_W-1:0];
      step      = (cmd_ff == CMD_WRITE) ? cnt_ff : k;
      bsum      = {1'b0, bit_ff} + step;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_item.command;
               data_in  = req_item.data_in;
               cnt_in   = cnt_c;
               bit_in   = base_bit;
               addr0_in = base_byte;
               addr1_in = base_next;
               state_in = (req_item.command == CMD_PEEK) ? ST_ADDR : ST_MOD;
            end
         end
         ST_ADDR: begin
            // peek position wrapped; the window read is under way now
            bit_in   = base_bit;
            addr0_in = base_byte;
            addr1_in = base_next;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            rsp_in           = '0;
            rsp_in.status    = STAT_OK;
            state_in         = ST_IDLE;
            strobe_in        = 1'b1;
            case (cmd_ff)
               CMD_WRITE: begin
                  if (overflow) begin
                     // drop the data and empty the queue
                     wr_byte_in    = '0;
                     wr_bit_in     = '0;
                     rd_byte_in    = '0;
                     rd_bit_in     = '0;
                     held_in       = '0;
                     rsp_in.status = STAT_OVERFLOW;
                  end else begin
                     ram_we    = (cnt_ff != '0);
                     wr_bit_in = bsum[2:0];
                     if (bsum[3]) begin
                        wr_byte_in = addr1_ff;
                     end
                     held_in     = held_plus[PW-1:0];
                     wr2_data_in = mrg.byte1;
                     if (mrg.spill) begin
                        // second byte goes out next cycle; hold the strobe
                        state_in  = ST_WR2;
                        strobe_in = 1'b0;
                     end
                  end
               end
               CMD_READ: begin
                  rd_bit_in = bsum[2:0];
                  if (bsum[3]) begin
                     rd_byte_in = addr1_ff;
                  end
                  held_in          = held_ff - PW'(k);
                  rsp_in.read_data = mrg.peek_bits & top_mask(k);
                  rsp_in.bits_read = k;
                  if (k < cnt_ff) begin
                     rsp_in.status = STAT_SHORT;
                  end
               end
               CMD_PEEK: begin
                  if (bad_ff) begin
                     rsp_in.status = STAT_PEEK_ERR;
                  end else begin
                     rsp_in.read_data = mrg.peek_bits;
                  end
               end
               default: begin
                  wr_byte_in = '0;
                  wr_bit_in  = '0;
                  rd_byte_in = '0;
                  rd_bit_in  = '0;
                  held_in    = '0;
               end
            endcase
            held_up           = {1'b0, held_in} + (PW+1)'(7);
            rsp_in.bits_held  = HELD_W'(held_in);
            rsp_in.bytes_held = BYTES_W'(held_up >> 3);
         end
         ST_WR2: begin
            ram_we    = 1'b1;
            ram_waddr = addr1_ff;
            ram_wdata = wr2_data_ff;
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      held_up = {1'b0, held_in} + (PW+1)'(7);

      // size register write: clamp to 1..STORE_DEPTH and empty the queue
      size_ext = CW'(csr_wr_data);
      if (csr_wr_en) begin
         if (size_ext == '0) begin
            ring_in = RW'(1);
         end else if (size_ext > CW'(STORE_DEPTH)) begin
            ring_in = RW'(STORE_DEPTH);
         end else begin
            ring_in = size_ext[RW-1:0];
         end
         wr_byte_in = '0;
         wr_bit_in  = '0;
         rd_byte_in = '0;
         rd_bit_in  = '0;
         held_in    = '0;
      end

      // advance the high-water mark past any byte written
      waddr_inc = RW'(ram_waddr) + RW'(1);
      hw_in     = (ram_we && (waddr_inc > hw_ff)) ? waddr_inc : hw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ring_ff    <= RW'(RING_RESET);
         hw_ff      <= '0;
         wr_byte_ff <= '0;
         wr_bit_ff  <= '0;
         rd_byte_ff <= '0;
         rd_bit_ff  <= '0;
         held_ff    <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ring_ff    <= ring_in;
         hw_ff      <= hw_in;
         wr_byte_ff <= wr_byte_in;
         wr_bit_ff  <= wr_bit_in;
         rd_byte_ff <= rd_byte_in;
         rd_bit_ff  <= rd_bit_in;
         held_ff    <= held_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      data_ff     <= data_in;
      cnt_ff      <= cnt_in;
      bit_ff      <= bit_in;
      addr0_ff    <= addr0_in;
      addr1_ff    <= addr1_in;
      wr2_data_ff <= wr2_data_in;
      rsp_ff      <= rsp_in;
      if (accept) begin
         bad_ff  <= bad_in;
         psum_ff <= psum_in;
      end
   end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit-granular ring FIFO. A job queue filled at
// time zero feeds a clocked driver with commands, ring-size writes and drain
// points; a clocked monitor compares every result strobe against a local
// bit-level mirror of the FIFO, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bgrf_pkg::*;

   localparam int MIRROR_AW = $clog2(STORE_DEPTH_DEF);

   typedef enum int {JOB_CMD, JOB_RESIZE, JOB_DRAIN} job_kind_type;

   typedef struct {
      job_kind_type       kind;
      req_type            cmd;
      logic [SIZE_W-1:0]  size;
      bit                 steady;   // never idle before this transfer
   } job_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic                busy;
   req_type             req_item    = '0;
   logic                rsp_strobe;
   rsp_type             rsp_item;
   logic                csr_wr_en   = 1'b0;
   logic [SIZE_W-1:0]   csr_wr_data = '0;

   job_type             pending_jobs[$];
   rsp_type             predicted_rsp[$];
   int unsigned         cmds_issued  = 0;
   int unsigned         rsps_checked = 0;
   bit                  all_sent     = 1'b0;
   int                  fail_count   = 0;

   // Mirror of the FIFO: byte store, bit positions of both ends, fill level
   bit [7:0]            mirror_bytes [STORE_DEPTH_DEF];
   int unsigned         mirror_wr_at = 0;
   int unsigned         mirror_rd_at = 0;
   int unsigned         mirror_held  = 0;
   logic [SIZE_W-1:0]   mirror_size  = SIZE_W'(SIZE_RESET);

   bit_granular_ring_fifo_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   // Ring capacity in bits; zero acts as one byte, oversize clamps to the store
   function automatic int unsigned ring_cap_bits(logic [SIZE_W-1:0] sz);
      int unsigned s;
      s = 32'(sz);
      if (s == 0) s = 1;
      if (s > STORE_DEPTH_DEF) s = STORE_DEPTH_DEF;
      return s * 8;
   endfunction

   function automatic void mirror_empty();
      mirror_wr_at = 0;
      mirror_rd_at = 0;
      mirror_held  = 0;
   endfunction

   function automatic bit mirror_bit(int unsigned pos);
      return mirror_bytes[MIRROR_AW'((pos >> 3) % STORE_DEPTH_DEF)][3'(7 - (pos & 7))];
   endfunction

   function automatic void mirror_put(int unsigned pos, bit v);
      mirror_bytes[MIRROR_AW'((pos >> 3) % STORE_DEPTH_DEF)][3'(7 - (pos & 7))] = v;
   endfunction

   // Apply one command to the mirror and return the result it must produce
   function automatic rsp_type bit_fifo_result(req_type r);
      int unsigned cap, cnt, pos, take, i;
      rsp_type     res;
      cap = ring_cap_bits(mirror_size);
      cnt = 32'(r.bit_count);
      res = '0;
      res.status = STAT_OK;
      if (cnt > MAX_BITS) cnt = 32'(MAX_BITS);
      case (r.command)
         CMD_WRITE: begin
            if (mirror_held + cnt > cap) begin
               mirror_empty();
               res.status = STAT_OVERFLOW;
            end else begin
               for (i = 0; i < cnt; i++) begin
                  mirror_put(mirror_wr_at, r.data_in[3'(7 - i)]);
                  mirror_wr_at = (mirror_wr_at + 1 >= cap) ? 0 : mirror_wr_at + 1;
               end
               mirror_held += cnt;
            end
         end
         CMD_READ: begin
            take = (cnt < mirror_held) ? cnt : mirror_held;
            for (i = 0; i < take; i++) begin
               res.read_data[3'(7 - i)] = mirror_bit(mirror_rd_at);
               mirror_rd_at = (mirror_rd_at + 1 >= cap) ? 0 : mirror_rd_at + 1;
            end
            mirror_held  -= take;
            res.bits_read = CNT_W'(take);
            if (take < cnt) res.status = STAT_SHORT;
         end
         CMD_PEEK: begin
            if (r.bit_offset >= cap) begin
               res.status = STAT_PEEK_ERR;
            end else begin
               pos = mirror_rd_at + r.bit_offset;
               if (pos >= cap) pos -= cap;
               for (i = 0; i < 8; i++) begin
                  res.read_data[3'(7 - i)] = mirror_bit(pos);
                  pos = (pos + 1 >= cap) ? 0 : pos + 1;
               end
            end
         end
         default: mirror_empty();
      endcase
      res.bits_held  = HELD_W'(mirror_held);
      res.bytes_held = BYTES_W'((mirror_held + 7) >> 3);
      return res;
   endfunction

   task automatic queue_cmd(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d,
                            logic [CNT_W-1:0] n, logic [OFFSET_W-1:0] o, bit steady);
      job_type j;
      j.kind           = JOB_CMD;
      j.cmd.command    = c;
      j.cmd.data_in    = d;
      j.cmd.bit_count  = n;
      j.cmd.bit_offset = o;
      j.size           = '0;
      j.steady         = steady;
      pending_jobs.push_back(j);
   endtask

   task automatic queue_other(job_kind_type k, logic [SIZE_W-1:0] sz);
      job_type j;
      j.kind   = k;
      j.cmd    = '0;
      j.size   = sz;
      j.steady = 1'b0;
      pending_jobs.push_back(j);
   endtask

   // ------------------------------------------------------------------------
   // Driver. A transfer happens at an edge with start high and busy low; the
   // expectation is computed right there so the mirror sees commands in the
   // same order as the block. Ring-size writes and drain points wait until
   // no result is owed, counted from register values of the previous step so
   // the outcome never depends on process order.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      bit          took;
      bit          nxt_start;
      bit          nxt_wr;
      int unsigned owed;
      job_type     j;
      if (!reset) begin
         took      = start && !busy;
         nxt_start = start && !took;   // hold an item that has not transferred
         nxt_wr    = 1'b0;
         owed      = cmds_issued - rsps_checked - (rsp_strobe ? 1 : 0);
         if (took) begin
            predicted_rsp.push_back(bit_fifo_result(req_item));
            cmds_issued <= cmds_issued + 1;
            owed++;
         end
         if (!nxt_start && pending_jobs.size() != 0) begin
            j = pending_jobs[0];
            case (j.kind)
               JOB_CMD: begin
                  // stay idle with a chance of 38 in 100 unless the job is in a steady run
                  if (j.steady || $urandom_range(0, 99) >= 38) begin
                     nxt_start = 1'b1;
                     req_item <= j.cmd;
                     void'(pending_jobs.pop_front());
                  end
               end
               JOB_RESIZE: begin
                  // write the ring size only with the block fully idle
                  if (owed == 0 && !busy) begin
                     nxt_wr       = 1'b1;
                     csr_wr_data <= j.size;
                     mirror_size  = j.size;
                     mirror_empty();
                     void'(pending_jobs.pop_front());
                  end
               end
               default: begin
                  // drain point: hold the sender until every result is back
                  if (owed == 0) void'(pending_jobs.pop_front());
               end
            endcase
         end
         if (!nxt_start && pending_jobs.size() == 0) all_sent <= 1'b1;
         start     <= nxt_start;
         csr_wr_en <= nxt_wr;
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: every strobe is a transfer the bench cannot refuse
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_strobe) begin
         rsps_checked <= rsps_checked + 1;
         if (predicted_rsp.size() == 0) begin
            $error("result strobe with no command outstanding");
            fail_count++;
         end else begin
            want = predicted_rsp.pop_front();
            check_field("read_data",  32'(want.read_data),  32'(rsp_item.read_data));
            check_field("bits_read",  32'(want.bits_read),  32'(rsp_item.bits_read));
            check_field("status",     32'(want.status),     32'(rsp_item.status));
            check_field("bits_held",  32'(want.bits_held),  32'(rsp_item.bits_held));
            check_field("bytes_held", 32'(want.bytes_held), 32'(rsp_item.bytes_held));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus plan, then reset, then wait for the job queue to run dry.
   // ------------------------------------------------------------------------
   initial begin : main_proc
      logic [SIZE_W-1:0] phase_sizes [11];
      int unsigned       phase_len, cap, wr_pct, roll, p, k;
      logic [CNT_W-1:0]  cnt;
      logic [OFFSET_W-1:0] off;
      logic [DATA_W-1:0] dat;
      bit                steady;

      // Directed: default ring of 1024 bytes
      queue_cmd(CMD_WRITE, 8'hFF, 4'd8,  13'd0, 1'b0);
      queue_cmd(CMD_WRITE, 8'h80, 4'd1,  13'd0, 1'b0);
      queue_cmd(CMD_WRITE, 8'h00, 4'd3,  13'd0, 1'b0);   // earlier bits of the byte stay
      queue_cmd(CMD_WRITE, 8'hA5, 4'd0,  13'd0, 1'b0);   // zero-length write
      queue_cmd(CMD_WRITE, 8'h5A, 4'd15, 13'd0, 1'b0);   // count above eight
      queue_cmd(CMD_READ,  8'h00, 4'd4,  13'd0, 1'b0);
      queue_cmd(CMD_READ,  8'hFF, 4'd0,  13'd0, 1'b0);   // zero-length read
      queue_cmd(CMD_PEEK,  8'h00, 4'd0,  13'd0, 1'b0);
      queue_cmd(CMD_PEEK,  8'h00, 4'd0,  13'h1FFF, 1'b0); // last bit, wraps
      queue_cmd(CMD_READ,  8'h00, 4'd15, 13'd0, 1'b0);
      queue_cmd(CMD_READ,  8'h00, 4'd8,  13'd0, 1'b0);
      queue_cmd(CMD_READ,  8'h00, 4'd8,  13'd0, 1'b0);   // short read
      queue_cmd(CMD_WRITE, 8'hC3, 4'd6,  13'd0, 1'b0);
      queue_cmd(CMD_CLEAR, 8'hFF, 4'd8,  13'd0, 1'b0);
      queue_cmd(CMD_PEEK,  8'h00, 4'd0,  13'd3, 1'b0);
      // Directed: one-byte ring, overflow and wraparound
      queue_other(JOB_RESIZE, 11'd1);
      queue_cmd(CMD_WRITE, 8'hFF, 4'd8,  13'd0, 1'b0);
      queue_cmd(CMD_WRITE, 8'h80, 4'd1,  13'd0, 1'b0);   // overflow
      queue_cmd(CMD_WRITE, 8'hE0, 4'd5,  13'd0, 1'b0);
      queue_cmd(CMD_READ,  8'h00, 4'd3,  13'd0, 1'b0);
      queue_cmd(CMD_WRITE, 8'h6C, 4'd6,  13'd0, 1'b0);   // wraps to full
      queue_cmd(CMD_PEEK,  8'h00, 4'd0,  13'd7, 1'b0);
      queue_cmd(CMD_PEEK,  8'h00, 4'd0,  13'd8, 1'b0);   // just out of range
      queue_cmd(CMD_PEEK,  8'h00, 4'd0,  13'h1FFF, 1'b0);
      queue_cmd(CMD_READ,  8'h00, 4'd8,  13'd0, 1'b0);
      // Directed: size zero and oversize both clamp
      queue_other(JOB_RESIZE, 11'd0);
      queue_cmd(CMD_WRITE, 8'h12, 4'd8,  13'd0, 1'b0);
      queue_other(JOB_RESIZE, 11'h7FF);
      queue_cmd(CMD_PEEK,  8'h00, 4'd0,  13'h1FFF, 1'b0);

      // Random phases over a spread of ring sizes
      phase_sizes = '{11'd3, 11'd1, 11'd2, 11'd17, 11'd64, 11'd1024,
                      11'd0, 11'd5, 11'd2047, 11'd9, 11'd1};
      for (p = 0; p < 11; p++) begin
         queue_other(JOB_RESIZE, phase_sizes[p]);
         cap       = ring_cap_bits(phase_sizes[p]);
         steady    = (p == 4);              // one long run with no idle cycles
         phase_len = steady ? 130 : 62;
         wr_pct    = $urandom_range(35, 65);
         for (k = 0; k < phase_len; k++) begin
            if (p == 2 && k == phase_len / 2) queue_other(JOB_DRAIN, '0);
            cnt = CNT_W'(($urandom_range(0, 9) == 0) ?
                         $urandom_range(0, 15) : $urandom_range(1, 8));
            off = OFFSET_W'(($urandom_range(0, 9) < 7) ?
                  ((cap + 1 > 8191) ? $urandom_range(0, 8191) : $urandom_range(0, cap + 1))
                  : $urandom_range(0, 8191));
            dat  = DATA_W'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < wr_pct)
               queue_cmd(CMD_WRITE, dat, cnt, off, steady);
            else if (roll < 85)
               queue_cmd(CMD_READ, dat, cnt, off, steady);
            else if (roll < 96)
               queue_cmd(CMD_PEEK, dat, cnt, off, steady);
            else
               queue_cmd(CMD_CLEAR, dat, cnt, off, steady);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (!all_sent || cmds_issued != rsps_checked);
      repeat (8) @(posedge clock);

      if (predicted_rsp.size() != 0) begin
         $error("%0d expected results never arrived", predicted_rsp.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire
